// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue.
// Holds the request and response payload types, operation codes and the
// command and status structs between the controller and the datapath.
package spq_pkg;

   // Default sizes of the queue.
   localparam int DEFAULT_DEPTH    = 16;
   localparam int DEFAULT_TAG_BITS = 16;

   // Operation codes carried in a request; the unused code acts as a peek.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   // One request.
   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] priority_req;
      logic [15:0]        tag;
   } req_type;

   // One response.
   typedef struct packed {
      logic               is_empty;
      logic               is_full;
      logic signed [15:0] head_priority;
      logic [15:0]        head_tag;
      logic               dropped;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic do_insert;
      logic do_delete;
      logic load_rsp;
      logic dropped;
   } spq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
   } spq_status_type;

   // States of the response register.
   typedef enum logic {
      ST_OUT_EMPTY,
      ST_OUT_HELD
   } spq_state_type;

endpackage

// ===== rtl/spq_ctrl.sv =====
// Controller of the sorted priority queue: request handshake, response
// register state and the commands for the datapath. Depends on spq_pkg.
module spq_ctrl
   import spq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [1:0]     req_operation,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  spq_status_type status,
   output spq_cmd_type    cmd
);

   spq_state_type state_ff, state_in;
   logic          accept;

   // A request is taken whenever the response register is free or drains now.
   assign req_stall = (state_ff == ST_OUT_HELD) && rsp_stall;
   assign rsp_valid = (state_ff == ST_OUT_HELD);
   assign accept    = req_valid && !req_stall;

   // Next state of the response register.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_OUT_EMPTY: begin
            if (accept) state_in = ST_OUT_HELD;
         end
         ST_OUT_HELD: begin
            if (!accept && !rsp_stall) state_in = ST_OUT_EMPTY;
         end
         default: begin
            state_in = ST_OUT_EMPTY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_OUT_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands for the datapath, decoded from the accepted request.
   always_comb begin
      cmd = '0;
      cmd.load_rsp = accept;
      case (req_operation)
         OP_INSERT: begin
            cmd.do_insert = accept && !status.full;
            cmd.dropped   = accept && status.full;
         end
         OP_DELETE: begin
            cmd.do_delete = accept && !status.empty;
         end
         default: begin
            cmd.do_insert = 1'b0;
         end
      endcase
   end

`ifndef SYNTHESIS
   // A stalled request side always means a response is waiting.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("request stalled with no response held");
   // An insert is never both performed and dropped.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_insert && cmd.dropped))
      else $error("insert both performed and dropped");
`endif

endmodule

// ===== rtl/spq_datapath.sv =====
// Datapath of the sorted priority queue: a row of compare-and-shift cells,
// the entry count and the response register. Depends on spq_pkg.
module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH    = DEFAULT_DEPTH,
   parameter int TAG_BITS = DEFAULT_TAG_BITS
) (
   input  logic           clock,
   input  logic           reset,
   input  spq_cmd_type    cmd,
   input  req_type        req_data,
   output spq_status_type status,
   output rsp_type        rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int TAG_W = (TAG_BITS < 16) ? TAG_BITS : 16;

   logic signed [15:0] cell_pri_ff [DEPTH];
   logic signed [15:0] cell_pri_in [DEPTH];
   logic [TAG_W-1:0]   cell_tag_ff [DEPTH];
   logic [TAG_W-1:0]   cell_tag_in [DEPTH];
   logic [DEPTH-1:0]   after;
   logic [CNT_W-1:0]   count_ff, count_in;
   rsp_type            rsp_ff, rsp_in;
   logic [TAG_W-1:0]   new_tag;

   assign new_tag = req_data.tag[TAG_W-1:0];

   // Each cell decides on its own whether the new entry lands behind it, and
   // keeps, takes the new entry or its left (insert) or right (delete) neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic valid;
      assign valid = CNT_W'(i) < count_ff;

      if (i == 0) begin : g_head
         // A tie with the head places the new entry behind the head.
         assign after[i] = valid && !(cell_pri_ff[i] > req_data.priority_req);
      end else begin : g_body
         assign after[i] = valid && (cell_pri_ff[i] < req_data.priority_req);
      end

      always_comb begin
         cell_pri_in[i] = cell_pri_ff[i];
         cell_tag_in[i] = cell_tag_ff[i];
         if (cmd.do_insert && !after[i]) begin
            if (i == 0) begin
               cell_pri_in[i] = req_data.priority_req;
               cell_tag_in[i] = new_tag;
            end else if (after[(i == 0) ? 0 : i - 1]) begin
               cell_pri_in[i] = req_data.priority_req;
               cell_tag_in[i] = new_tag;
            end else begin
               cell_pri_in[i] = cell_pri_ff[(i == 0) ? 0 : i - 1];
               cell_tag_in[i] = cell_tag_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (cmd.do_delete && (i < DEPTH - 1)) begin
            cell_pri_in[i] = cell_pri_ff[(i < DEPTH - 1) ? i + 1 : i];
            cell_tag_in[i] = cell_tag_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end

      always_ff @(posedge clock) begin
         cell_pri_ff[i] <= cell_pri_in[i];
         cell_tag_ff[i] <= cell_tag_in[i];
      end
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (cmd.do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.do_delete) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

   // Response built from the state after this request.
   always_comb begin
      rsp_in.is_empty      = (count_in == '0);
      rsp_in.is_full       = (count_in == CNT_W'(DEPTH));
      rsp_in.dropped       = cmd.dropped;
      rsp_in.head_priority = '0;
      rsp_in.head_tag      = '0;
      if (count_in != '0) begin
         rsp_in.head_priority = cell_pri_in[0];
         rsp_in.head_tag      = 16'(cell_tag_in[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   // The count never passes the depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");
   // A performed insert grows the count by one.
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the count");
   // The two front entries stay in order.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (cell_pri_ff[0] <= cell_pri_ff[1]))
      else $error("front entries out of order");
`endif

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: joins the controller and the
// datapath. Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   req_data (req_type)
//   rsp_      out        rsp_valid / rsp_stall   rsp_data (rsp_type)
//
// For each request the cell row compares all entries with the new priority
// in parallel and shifts in the same cycle, so one request is accepted per
// cycle while responses are taken.
// The response stands in an output register in the cycle after acceptance.
// Reset clears the entry count and the response state; the cells need no
// clearing pass.
// A held response stalls requests only while rsp_stall is high.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH    = DEFAULT_DEPTH,
   parameter int TAG_BITS = DEFAULT_TAG_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   spq_cmd_type    cmd;
   spq_status_type status;

   // Handshake and command decode.
   spq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_data.operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // Sorted cells, count and response register.
   spq_datapath #(
      .DEPTH    (DEPTH),
      .TAG_BITS (TAG_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
